// ===== rtl/core/fcg_pkg.sv =====
// Shared types and constants for the FIR convolver with output gain.
// Holds field widths, command and register codes, the controller state
// type and the command and status bundles. Depends on nothing.
`default_nettype none

package fcg_pkg;

    // Field widths of the streaming and configuration payloads.
    localparam int TAP_IDX_W  = 13;
    localparam int TAP_W      = 24;
    localparam int SAMPLE_W   = 24;
    localparam int OUT_W      = 16;
    localparam int IRLEN_W    = 14;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    // Positions of the fields inside the slave-side tdata.
    localparam int TAP_IDX_LSB = 0;
    localparam int TAP_VAL_LSB = TAP_IDX_LSB + TAP_IDX_W;
    localparam int SAMPLE_LSB  = TAP_VAL_LSB + TAP_W;

    // Arithmetic constants.
    localparam int PROD_W        = TAP_W + SAMPLE_W;
    localparam int BYPASS_SHIFT  = 23;
    localparam int FULL_BIT      = 56;
    localparam int SCALE_BITS    = 15;
    localparam int SCALED_W      = FULL_BIT + 1 + SCALE_BITS;
    localparam int MUL_CNT_W     = $clog2(GAIN_W + 1);

    localparam logic [GAIN_W-1:0]      GAIN_RESET = 15'd4106;
    localparam logic signed [OUT_W-1:0] OUT_MAX   = 16'sd32767;

    // Command codes carried in the slave-side tuser.
    localparam logic CMD_TAP_WRITE = 1'b0;
    localparam logic CMD_SAMPLE    = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BYPASS,
        ST_HIST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_ABS,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } fcg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // request accepted: latch fields, apply a tap write
        logic load_sample;  // accumulator takes the sample, bypass path
        logic hist_wr;      // store sample in history, clear accumulator
        logic mac_issue;    // read one tap and one history entry
        logic abs_ld;       // split accumulator into sign and magnitude
        logic mul_step;     // one shift-and-add step of the gain multiply
        logic scale;        // clamp and scale to the output range
        logic out_load;     // load the output register
    } fcg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mac_busy;     // products still in flight
        logic out_free;     // output register can take a new result
    } fcg_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcg_ctrl.sv =====
// Controller state machine for the FIR convolver with output gain.
// Sequences the history write, the tap loop and the gain stage.
// Depends on fcg_pkg.
`default_nettype none

module fcg_ctrl #(
    parameter int MAX_TAPS = 8192
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              in_command,
    input  wire  [fcg_pkg::IRLEN_W-1:0]      ir_length,
    input  wire                              bypass,
    output fcg_pkg::fcg_cmd_t                cmd,
    input  fcg_pkg::fcg_status_t             status
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = ADDR_W + 1;

    fcg_pkg::fcg_state_t               state_reg, state_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [fcg_pkg::MUL_CNT_W-1:0]     mul_cnt_reg, mul_cnt_next;
    logic [CNT_W-1:0]                  len;

    // Taps in use, saturated to the size of the stores.
    always_comb
    begin
        if (32'(ir_length) > 32'(MAX_TAPS))
        begin
            len = CNT_W'(MAX_TAPS);
        end
        else
        begin
            len = CNT_W'(ir_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fcg_pkg::ST_IDLE;
            cnt_reg     <= '0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mul_cnt_reg <= mul_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mul_cnt_next = mul_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            fcg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_command == fcg_pkg::CMD_SAMPLE)
                    begin
                        if (bypass || (len == '0))
                        begin
                            state_next = fcg_pkg::ST_BYPASS;
                        end
                        else
                        begin
                            state_next = fcg_pkg::ST_HIST_WRITE;
                        end
                    end
                end
            end
            fcg_pkg::ST_BYPASS:
            begin
                cmd.load_sample = 1'b1;
                state_next      = fcg_pkg::ST_ABS;
            end
            fcg_pkg::ST_HIST_WRITE:
            begin
                cmd.hist_wr = 1'b1;
                cnt_next    = len;
                state_next  = fcg_pkg::ST_MAC;
            end
            fcg_pkg::ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = fcg_pkg::ST_DRAIN;
                end
            end
            fcg_pkg::ST_DRAIN:
            begin
                if (!status.mac_busy)
                begin
                    state_next = fcg_pkg::ST_ABS;
                end
            end
            fcg_pkg::ST_ABS:
            begin
                cmd.abs_ld   = 1'b1;
                mul_cnt_next = fcg_pkg::MUL_CNT_W'(fcg_pkg::GAIN_W);
                state_next   = fcg_pkg::ST_MUL;
            end
            fcg_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == fcg_pkg::MUL_CNT_W'(1))
                begin
                    state_next = fcg_pkg::ST_SCALE;
                end
            end
            fcg_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = fcg_pkg::ST_OUT;
            end
            fcg_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/fcg_datapath.sv =====
// Datapath for the FIR convolver with output gain: tap and history stores,
// the multiply-accumulate pipe, the serial gain multiply, clamp and output
// register. Driven by fcg_ctrl; depends on fcg_pkg.
`default_nettype none

module fcg_datapath #(
    parameter int MAX_TAPS = 8192
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  fcg_pkg::fcg_cmd_t                    cmd,
    output fcg_pkg::fcg_status_t                 status,
    input  wire                                  in_command,
    input  wire  [fcg_pkg::TAP_IDX_W-1:0]        tap_index,
    input  wire  signed [fcg_pkg::TAP_W-1:0]     tap_value,
    input  wire  signed [fcg_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire  [fcg_pkg::GAIN_W-1:0]           gain_level,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [fcg_pkg::OUT_W-1:0]     sample_out,
    output logic                                 clipped
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int ACC_W  = fcg_pkg::PROD_W + ADDR_W + 1;
    localparam int Q_W    = ACC_W + fcg_pkg::GAIN_W;
    localparam int FB     = fcg_pkg::FULL_BIT;

    logic signed [fcg_pkg::TAP_W-1:0]    tap_mem  [MAX_TAPS];
    logic signed [fcg_pkg::SAMPLE_W-1:0] hist_mem [MAX_TAPS];

    // Control state.
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              rd_valid_reg, prod_valid_reg, out_valid_reg;
    logic              out_valid_next;

    // Payload.
    logic signed [fcg_pkg::SAMPLE_W-1:0] sample_reg;
    logic [ADDR_W-1:0]                   tap_ptr_reg, tap_ptr_next;
    logic [ADDR_W-1:0]                   hist_ptr_reg, hist_ptr_next;
    logic signed [fcg_pkg::TAP_W-1:0]    tap_rd_reg;
    logic signed [fcg_pkg::SAMPLE_W-1:0] hist_rd_reg;
    logic                                hv_reg;
    logic signed [fcg_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]             acc_reg, acc_next;
    logic [ACC_W-1:0]                    mag_reg, mag_next;
    logic                                neg_reg;
    logic [fcg_pkg::GAIN_W-1:0]          gain_sh_reg, gain_sh_next;
    logic [Q_W-1:0]                      q_reg, q_next;
    logic [fcg_pkg::OUT_W-1:0]           res_reg, res_next;
    logic                                clip_reg, clip_next;
    logic signed [fcg_pkg::OUT_W-1:0]    out_data_reg, out_data_next;
    logic                                out_clip_reg;

    logic                                tap_we;
    logic [ADDR_W-1:0]                   tap_addr;
    logic                                hv_next;
    logic signed [fcg_pkg::SAMPLE_W-1:0] hist_sel;
    logic [fcg_pkg::SCALED_W-1:0]        scaled;

    assign tap_addr = ADDR_W'(tap_index);
    assign tap_we   = cmd.capture && (in_command == fcg_pkg::CMD_TAP_WRITE)
                      && (32'(tap_index) < 32'(MAX_TAPS));

    // A history entry counts only once written since the last clear; writes
    // run upwards from slot zero, so the fill count marks the valid slots.
    assign hv_next  = ({1'b0, hist_ptr_reg} < fill_reg);
    assign hist_sel = hv_reg ? hist_rd_reg : '0;

    assign status.mac_busy = rd_valid_reg || prod_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // Stores with registered reads.
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_addr] <= tap_value;
        end
        if (cmd.mac_issue)
        begin
            tap_rd_reg <= tap_mem[tap_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
        begin
            hist_mem[wp_reg] <= sample_reg;
        end
        if (cmd.mac_issue)
        begin
            hist_rd_reg <= hist_mem[hist_ptr_reg];
        end
    end

    // Write position and fill count.
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (tap_we)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (cmd.hist_wr)
        begin
            wp_next = (wp_reg == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != CNT_W'(MAX_TAPS))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Read pointers: taps count up from zero, history counts down and wraps.
    always_comb
    begin
        tap_ptr_next  = tap_ptr_reg;
        hist_ptr_next = hist_ptr_reg;
        if (cmd.hist_wr)
        begin
            tap_ptr_next  = '0;
            hist_ptr_next = wp_reg;
        end
        else if (cmd.mac_issue)
        begin
            tap_ptr_next  = tap_ptr_reg + 1'b1;
            hist_ptr_next = (hist_ptr_reg == '0) ? ADDR_W'(MAX_TAPS - 1)
                                                 : hist_ptr_reg - 1'b1;
        end
    end

    assign prod_next = tap_rd_reg * hist_sel;

    // Accumulator and sign-magnitude split.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load_sample)
        begin
            acc_next = ACC_W'(sample_reg) <<< fcg_pkg::BYPASS_SHIFT;
        end
        else if (cmd.hist_wr)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        mag_next = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    end

    // Gain multiply, one gain bit per step, most significant first.
    always_comb
    begin
        q_next       = q_reg;
        gain_sh_next = gain_sh_reg;
        if (cmd.abs_ld)
        begin
            q_next       = '0;
            gain_sh_next = gain_level;
        end
        else if (cmd.mul_step)
        begin
            q_next = {q_reg[Q_W-2:0], 1'b0}
                     + (gain_sh_reg[fcg_pkg::GAIN_W-1] ? Q_W'(mag_reg) : '0);
            gain_sh_next = gain_sh_reg << 1;
        end
    end

    // Clamp above full scale, otherwise scale by 32767 and truncate.
    always_comb
    begin
        scaled    = {q_reg[FB:0], {fcg_pkg::SCALE_BITS{1'b0}}}
                    - {{fcg_pkg::SCALE_BITS{1'b0}}, q_reg[FB:0]};
        clip_next = (q_reg[Q_W-1:FB+1] != '0) || (q_reg[FB] && (q_reg[FB-1:0] != '0));
        res_next  = clip_next ? fcg_pkg::OUT_MAX
                              : scaled[fcg_pkg::SCALED_W-1:fcg_pkg::SCALED_W-fcg_pkg::OUT_W];
        out_data_next = neg_reg ? -$signed(res_reg) : $signed(res_reg);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            fill_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            rd_valid_reg   <= cmd.mac_issue;
            prod_valid_reg <= rd_valid_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.mac_issue)
        begin
            hv_reg <= hv_next;
        end
        tap_ptr_reg  <= tap_ptr_next;
        hist_ptr_reg <= hist_ptr_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        if (cmd.abs_ld)
        begin
            mag_reg <= mag_next;
            neg_reg <= acc_reg[ACC_W-1];
        end
        gain_sh_reg <= gain_sh_next;
        q_reg       <= q_next;
        if (cmd.scale)
        begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_clip_reg <= clip_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign clipped    = out_clip_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fir_convolver_with_output_gain.sv =====
// A tap write is stored as it is accepted and gives no result. A sample goes to history,
// then through ir_length taps at one tap per cycle (ir_length saturating at MAX_TAPS),
// then 15 gain steps and the clamp into the output register; bypassed or with ir_length
// zero, it skips history and taps. One request is worked at a time and the next is
// taken in the cycle after the result is loaded. Reset clears control, ir_length and
// bypass and loads gain 4106; history reads as zero through a fill count.
`default_nettype none

module fir_convolver_with_output_gain #(
    parameter int MAX_TAPS = 8192
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // Input stream.
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: tap_index[12:0], tap_value[36:13], sample_in[60:37], zero fill.
    input  wire  [fcg_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: command (0 = tap write, 1 = sample).
    input  wire                                s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // tdata from bit 0: sample_out[15:0].
    output logic [fcg_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: clipped.
    output logic                               m_axis_tuser,
    // Configuration write channel.
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [fcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [fcg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers. Writes are to be made only while the block is idle, which the
    // block itself does not enforce; they are taken at once and need no holding.
    logic [fcg_pkg::IRLEN_W-1:0] ir_length_reg, ir_length_next;
    logic                        bypass_reg, bypass_next;
    logic [fcg_pkg::GAIN_W-1:0]  gain_reg, gain_next;

    fcg_pkg::fcg_cmd_t    cmd;
    fcg_pkg::fcg_status_t status;

    logic signed [fcg_pkg::OUT_W-1:0] sample_out;

    assign cfg_ready = 1'b1;

    // Register indexes beyond the list are accepted and ignored.
    always_comb
    begin
        ir_length_next = ir_length_reg;
        bypass_next    = bypass_reg;
        gain_next      = gain_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fcg_pkg::REG_IR_LENGTH: ir_length_next = cfg_data[fcg_pkg::IRLEN_W-1:0];
                fcg_pkg::REG_BYPASS:    bypass_next    = cfg_data[0];
                fcg_pkg::REG_GAIN:      gain_next      = cfg_data[fcg_pkg::GAIN_W-1:0];
                default:                ir_length_next = ir_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_length_reg <= '0;
            bypass_reg    <= 1'b0;
            gain_reg      <= fcg_pkg::GAIN_RESET;
        end
        else
        begin
            ir_length_reg <= ir_length_next;
            bypass_reg    <= bypass_next;
            gain_reg      <= gain_next;
        end
    end

    // The controller accepts a request only when idle; the output register in
    // the datapath lets it take the next request while a result waits.
    fcg_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .ir_length  (ir_length_reg),
        .bypass     (bypass_reg),
        .cmd        (cmd),
        .status     (status)
    );

    fcg_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_command  (s_axis_tuser),
        .tap_index   (s_axis_tdata[fcg_pkg::TAP_VAL_LSB-1:fcg_pkg::TAP_IDX_LSB]),
        .tap_value   (s_axis_tdata[fcg_pkg::SAMPLE_LSB-1:fcg_pkg::TAP_VAL_LSB]),
        .sample_in   (s_axis_tdata[fcg_pkg::SAMPLE_LSB+fcg_pkg::SAMPLE_W-1:
                                   fcg_pkg::SAMPLE_LSB]),
        .gain_level  (gain_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .sample_out  (sample_out),
        .clipped     (m_axis_tuser)
    );

    assign m_axis_tdata = sample_out;

endmodule

`default_nettype wire
